[rtl/arfl_pkg.sv]
// arfl_pkg: types, codes and constants of the address range free-list allocator
// used by arfl_cell and address_range_free_list_allocator; no dependencies
package arfl_pkg;

  localparam int ADDR_W = 64;
  localparam int CFG_IDX_W = 2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NOMEM    = 2'd3;

  // operation codes
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_TEST  = 2'd2;
  localparam logic [1:0] FN_BAD   = 2'd3;  // undefined operation

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] req_address;
    logic [ADDR_W-1:0] req_length;
    logic [ADDR_W-1:0] req_alignment;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic              span_allocated;
  } rsp_t;

  // request operands as the cells see them
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] align;
    logic [ADDR_W-1:0] mask;
  } work_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;    // addr below start
    logic ffit;  // fixed span inside range
    logic afit;  // aligned span fits range
    logic zl;    // length equals size
    logic tail;  // fixed span ends at range end
    logic padx;  // leftover equals pad
    logic pz;    // start already aligned
    logic aeq;   // addr equals start
    logic ea;    // start equals span end
    logic eb;    // range end equals addr
    logic brk;   // span ends at or before start
    logic ov;    // addr below range end
  } cell_flags_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_LOAD,
    C_TRIM_HEAD,
    C_REMOVE_HEAD,
    C_TRIM_TAIL,
    C_SPLIT_FIX,
    C_PAD_ONLY,
    C_SPLIT_ANY,
    C_FREE_A,
    C_A_MERGE,
    C_FREE_B,
    C_B_MERGE,
    C_INSERT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ADDR_W-1:0] load_start;
    logic [ADDR_W-1:0] load_len;
  } cmd_t;

endpackage

[rtl/address_range_free_list_allocator.sv]
// address_range_free_list_allocator: top level, control sequencer over the cell chain
// depends on arfl_pkg, arfl_cell and arfl_first
//
// Keeps the free ranges of one address region in a row of MAX_RANGES cells, sorted by
// start address. Each beat on the request channel is an allocate (first fit at a
// power-of-two alignment, or at a fixed address), a free (joined with neighbors on
// both sides) or a span test, and gives exactly one response beat. All cells compare
// the request against their range at once; a find-first picks the entry, the
// update is decided, and then every cell loads its own or a neighbor's range at the
// same time, so inserts and removals shift the whole row at once. A request runs
// through the steps compare, select, decide, shift and respond before the next is
// accepted; the first operation after reset adds a load step that puts the region
// into cell 0, and an unknown operation goes straight to respond. The region
// registers are sampled when that first operation loads the table; later writes only
// move the bounds check of fixed-address allocations. There is no clearing pass.
module address_range_free_list_allocator #(
  parameter int MAX_RANGES = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  arfl_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output arfl_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arfl_pkg::ADDR_W-1:0]       cfg_data
);

  localparam int N     = MAX_RANGES;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int AW    = arfl_pkg::ADDR_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_SEL   = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration and table control
  logic [AW-1:0]    region_base, region_length;
  logic [CNT_W-1:0] count;
  logic             untouched;
  logic [AW-1:0]    usable;

  // request held for the whole operation
  arfl_pkg::work_t  work;
  logic [1:0]       func;
  logic             bad_align;
  logic             fixed;

  // per-stage registers
  arfl_pkg::cell_flags_t flags_q [N];
  logic [N-1:0]     hits_q;
  logic [1:0]       pre_status;
  logic             skip;
  logic             found_q;
  logic [IDX_W-1:0] k_q;
  arfl_pkg::cmd_op_t op_q;
  logic [IDX_W-1:0] cmd_index_q;
  arfl_pkg::rsp_t   res_q;

  // cell chain wiring
  logic [AW-1:0] start_a [N];
  logic [AW-1:0] len_a   [N];
  logic [AW-1:0] pad_a   [N];
  logic [AW-1:0] cand_a  [N];
  arfl_pkg::cell_flags_t cflags [N];
  arfl_pkg::cmd_t cmd;
  logic [IDX_W-1:0] cmd_index;

  logic             found_w;
  logic [IDX_W-1:0] k_w;

  assign cfg_ready = 1'b1;
  assign req_stall = state != S_IDLE;
  assign usable    = (region_length > ~region_base) ? ~region_base : region_length;

  // region registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base   <= '0;
      region_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arfl_pkg::CFG_BASE:   region_base   <= cfg_data;
        arfl_pkg::CFG_LENGTH: region_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // broadcast command to the chain
  always_comb begin
    cmd.load_start = region_base;
    cmd.load_len   = usable;
    cmd_index      = cmd_index_q;
    if (state == S_LOAD) begin
      cmd.op = arfl_pkg::C_LOAD;
    end else if (state == S_APPLY) begin
      cmd.op = op_q;
    end else begin
      cmd.op = arfl_pkg::C_NONE;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [AW-1:0] ls, ll, lp, rs, rl;
    if (i == 0) begin : g_left_edge
      assign ls = '0;
      assign ll = '0;
      assign lp = '0;
    end else begin : g_left
      assign ls = start_a[i-1];
      assign ll = len_a[i-1];
      assign lp = pad_a[i-1];
    end
    if (i == N - 1) begin : g_right_edge
      assign rs = '0;
      assign rl = '0;
    end else begin : g_right
      assign rs = start_a[i+1];
      assign rl = len_a[i+1];
    end
    arfl_cell #(.IDX_W(IDX_W)) u_cell (
      .clk         (clk),
      .my_index    (IDX_W'(i)),
      .cmd         (cmd),
      .cmd_index   (cmd_index),
      .work        (work),
      .left_start  (ls),
      .left_len    (ll),
      .left_pad    (lp),
      .right_start (rs),
      .right_len   (rl),
      .start       (start_a[i]),
      .len         (len_a[i]),
      .pad         (pad_a[i]),
      .cand        (cand_a[i]),
      .flags       (cflags[i])
    );
  end

  arfl_first #(.N(N), .IDX_W(IDX_W)) u_first (
    .hits  (hits_q),
    .found (found_w),
    .index (k_w)
  );

  // hit vector, picked by operation, for entries below the fill count
  logic [N-1:0] hits_w;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic v;
      v = CNT_W'(i) < count;
      case (func)
        arfl_pkg::FN_ALLOC: begin
          hits_w[i] = v && (fixed ? (cflags[i].lt || cflags[i].ffit) : cflags[i].afit);
        end
        arfl_pkg::FN_FREE: begin
          hits_w[i] = v && (cflags[i].ea || cflags[i].eb || cflags[i].lt);
        end
        arfl_pkg::FN_TEST: hits_w[i] = v && (cflags[i].brk || cflags[i].ov);
        default:           hits_w[i] = 1'b0;
      endcase
    end
  end

  // argument checks ahead of the table search
  logic [1:0] pre_w;
  logic       skip_w;
  always_comb begin
    pre_w  = arfl_pkg::ST_OK;
    skip_w = 1'b0;
    case (func)
      arfl_pkg::FN_ALLOC: begin
        if (bad_align || work.size == '0 || (work.addr & work.mask) != '0) begin
          pre_w = arfl_pkg::ST_INVALID;
        end else if (work.size > ~work.addr) begin
          pre_w = arfl_pkg::ST_OVERFLOW;
        end else if (fixed && (work.addr < region_base ||
                               (work.end_addr - region_base) > usable)) begin
          pre_w = arfl_pkg::ST_NOMEM;
        end
      end
      arfl_pkg::FN_FREE: begin
        if (work.size > ~work.addr) begin
          pre_w = arfl_pkg::ST_OVERFLOW;
        end else if (work.size == '0) begin
          skip_w = 1'b1;
        end
      end
      arfl_pkg::FN_TEST: begin
        if (work.size > ~work.addr) pre_w = arfl_pkg::ST_OVERFLOW;
      end
      default: pre_w = arfl_pkg::ST_INVALID;
    endcase
  end

  // start address of the first fit, taken from the chosen cell
  logic [AW-1:0] grant_any;
  always_comb begin
    grant_any = '0;
    for (int i = 0; i < N; i++) begin
      grant_any = grant_any | ({AW{k_q == IDX_W'(i)}} & cand_a[i]);
    end
  end

  // decide the update from the flags of the chosen entry and its neighbors
  arfl_pkg::cell_flags_t fk, fprev, fnext;
  logic [IDX_W-1:0] k_prev, k_next;
  logic             has_prev, has_next, full;
  arfl_pkg::cmd_op_t op_w;
  logic [IDX_W-1:0] idx_w;
  arfl_pkg::rsp_t   res_w;

  always_comb begin
    k_prev   = (k_q == '0) ? '0 : k_q - IDX_W'(1);
    k_next   = (k_q == IDX_W'(N - 1)) ? k_q : k_q + IDX_W'(1);
    has_prev = k_q != '0;
    has_next = (CNT_W'(k_q) + CNT_W'(1)) < count;
    full     = count == CNT_W'(N);
    fk       = flags_q[k_q];
    fprev    = flags_q[k_prev];
    fnext    = flags_q[k_next];

    op_w  = arfl_pkg::C_NONE;
    idx_w = k_q;
    res_w = '0;
    res_w.status = arfl_pkg::ST_OK;

    if (pre_status != arfl_pkg::ST_OK) begin
      res_w.status = pre_status;
    end else if (!skip) begin
      case (func)
        arfl_pkg::FN_ALLOC: begin
          if (fixed) begin
            if (!found_q || fk.lt) begin
              res_w.status = arfl_pkg::ST_NOMEM;
            end else if (fk.aeq) begin
              op_w = fk.zl ? arfl_pkg::C_REMOVE_HEAD : arfl_pkg::C_TRIM_HEAD;
            end else if (fk.tail) begin
              op_w = arfl_pkg::C_TRIM_TAIL;
            end else if (full) begin
              res_w.status = arfl_pkg::ST_NOMEM;
            end else begin
              op_w = arfl_pkg::C_SPLIT_FIX;
            end
            if (res_w.status == arfl_pkg::ST_OK) res_w.granted_address = work.addr;
          end else begin
            if (!found_q) begin
              res_w.status = arfl_pkg::ST_NOMEM;
            end else if (fk.pz) begin
              op_w = fk.zl ? arfl_pkg::C_REMOVE_HEAD : arfl_pkg::C_TRIM_HEAD;
            end else if (fk.padx) begin
              op_w = arfl_pkg::C_PAD_ONLY;
            end else if (full) begin
              res_w.status = arfl_pkg::ST_NOMEM;
            end else begin
              op_w = arfl_pkg::C_SPLIT_ANY;
            end
            if (res_w.status == arfl_pkg::ST_OK) res_w.granted_address = grant_any;
          end
        end
        arfl_pkg::FN_FREE: begin
          if (!found_q) begin
            // append after the last entry
            idx_w = count[IDX_W-1:0];
            if (full) res_w.status = arfl_pkg::ST_NOMEM;
            else      op_w = arfl_pkg::C_INSERT;
          end else if (fk.ea) begin
            op_w = (has_prev && fprev.eb) ? arfl_pkg::C_A_MERGE : arfl_pkg::C_FREE_A;
          end else if (fk.eb) begin
            op_w = (has_next && fnext.ea) ? arfl_pkg::C_B_MERGE : arfl_pkg::C_FREE_B;
          end else if (full) begin
            res_w.status = arfl_pkg::ST_NOMEM;
          end else begin
            op_w = arfl_pkg::C_INSERT;
          end
        end
        arfl_pkg::FN_TEST: res_w.span_allocated = !found_q || fk.brk;
        default: res_w.status = arfl_pkg::ST_INVALID;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          if (!(req.func inside {arfl_pkg::FN_ALLOC, arfl_pkg::FN_FREE,
                                 arfl_pkg::FN_TEST})) begin
            state_next = S_DONE;
          end else if (untouched) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_EVAL;
          end
        end
      end
      S_LOAD:  state_next = S_EVAL;
      S_EVAL:  state_next = S_SEL;
      S_SEL:   state_next = S_DEC;
      S_DEC:   state_next = S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic [AW-1:0] align_eff;
  assign align_eff = (req.req_alignment == '0) ? AW'(PAGE_BYTES) : req.req_alignment;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      untouched <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        untouched <= 1'b0;
        count     <= (usable != '0) ? CNT_W'(1) : '0;
      end
      if (state == S_APPLY) begin
        case (op_q)
          arfl_pkg::C_SPLIT_FIX, arfl_pkg::C_SPLIT_ANY, arfl_pkg::C_INSERT:
            count <= count + CNT_W'(1);
          arfl_pkg::C_REMOVE_HEAD, arfl_pkg::C_A_MERGE, arfl_pkg::C_B_MERGE:
            count <= count - CNT_W'(1);
          default: ;
        endcase
      end
      // response beat leaves when the output register is free or being taken
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      func          <= req.func;
      fixed         <= req.req_address != '0;
      bad_align     <= (req.req_alignment != '0) &&
                       ((req.req_alignment & (req.req_alignment - AW'(1))) != '0);
      work.addr     <= req.req_address;
      work.size     <= req.req_length;
      work.end_addr <= req.req_address + req.req_length;
      work.align    <= align_eff;
      work.mask     <= align_eff - AW'(1);
      res_q         <= '{status: arfl_pkg::ST_INVALID, granted_address: '0,
                         span_allocated: 1'b0};
    end
    if (state == S_EVAL) begin
      hits_q     <= hits_w;
      pre_status <= pre_w;
      skip       <= skip_w;
      for (int i = 0; i < N; i++) flags_q[i] <= cflags[i];
    end
    if (state == S_SEL) begin
      found_q <= found_w;
      k_q     <= k_w;
    end
    if (state == S_DEC) begin
      op_q        <= op_w;
      cmd_index_q <= idx_w;
      res_q       <= res_w;
    end
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp <= res_q;
    end
  end

  // the fill count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(N))
    else $error("free range count above table size");

  // an insert grows the table by exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && op_q == arfl_pkg::C_INSERT) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  // a failed operation reports no grant and no test hit
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != arfl_pkg::ST_OK) |->
      (rsp.granted_address == '0 && !rsp.span_allocated))
    else $error("failing response carries a result");

  // the region is loaded only by the load step
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    $fell(untouched) |-> $past(state) == S_LOAD)
    else $error("region loaded outside the load step");

endmodule

[rtl/arfl_first.sv]
// arfl_first: find-first-set over the hit vector of the cell chain
// depends on nothing but its parameters
module arfl_first #(
  parameter int N = 64,
  parameter int IDX_W = 6
) (
  input  logic [N-1:0]     hits,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  logic [N-1:0] lowest;

  assign lowest = hits & ~(hits - N'(1));
  assign found  = |hits;

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      index = index | ({IDX_W{lowest[i]}} & IDX_W'(i));
    end
  end

endmodule

[rtl/arfl_cell.sv]
// arfl_cell: one free-range entry of the chain, with its compares and shift logic
// depends on arfl_pkg
module arfl_cell #(
  parameter int IDX_W = 6
) (
  input  logic                         clk,
  input  logic [IDX_W-1:0]             my_index,
  input  arfl_pkg::cmd_t               cmd,
  input  logic [IDX_W-1:0]             cmd_index,
  input  arfl_pkg::work_t              work,
  input  logic [arfl_pkg::ADDR_W-1:0]  left_start,
  input  logic [arfl_pkg::ADDR_W-1:0]  left_len,
  input  logic [arfl_pkg::ADDR_W-1:0]  left_pad,
  input  logic [arfl_pkg::ADDR_W-1:0]  right_start,
  input  logic [arfl_pkg::ADDR_W-1:0]  right_len,
  output logic [arfl_pkg::ADDR_W-1:0]  start,
  output logic [arfl_pkg::ADDR_W-1:0]  len,
  output logic [arfl_pkg::ADDR_W-1:0]  pad,
  output logic [arfl_pkg::ADDR_W-1:0]  cand,
  output arfl_pkg::cell_flags_t        flags
);

  logic [arfl_pkg::ADDR_W-1:0] offs, rem, start_next, len_next;
  logic is_k, is_kp1, is_km1, gt_k, gt_kp1;

  assign offs = start & work.mask;
  assign pad  = (offs == '0) ? '0 : work.align - offs;
  assign rem  = len - work.size;
  assign cand = start + pad;

  always_comb begin
    flags.lt   = work.addr < start;
    flags.ffit = !((work.addr - start) >= len) && !((work.end_addr - start) > len);
    flags.afit = (len >= work.size) && (rem >= pad);
    flags.zl   = len == work.size;
    flags.tail = (work.end_addr - start) == len;
    flags.padx = rem == pad;
    flags.pz   = offs == '0;
    flags.aeq  = work.addr == start;
    flags.ea   = start == work.end_addr;
    flags.eb   = (start + len) == work.addr;
    flags.brk  = work.end_addr <= start;
    flags.ov   = work.addr < (start + len);
  end

  assign is_k   = my_index == cmd_index;
  assign is_kp1 = (IDX_W+1)'(my_index) == ((IDX_W+1)'(cmd_index) + (IDX_W+1)'(1));
  assign is_km1 = ((IDX_W+1)'(my_index) + (IDX_W+1)'(1)) == (IDX_W+1)'(cmd_index);
  assign gt_k   = my_index > cmd_index;
  assign gt_kp1 = gt_k && !is_kp1;

  always_comb begin
    start_next = start;
    len_next   = len;
    case (cmd.op)
      arfl_pkg::C_LOAD: begin
        if (my_index == '0) begin
          start_next = cmd.load_start;
          len_next   = cmd.load_len;
        end
      end
      arfl_pkg::C_TRIM_HEAD: begin
        if (is_k) begin
          start_next = start + work.size;
          len_next   = rem;
        end
      end
      arfl_pkg::C_REMOVE_HEAD: begin
        if (is_k || gt_k) begin
          start_next = right_start;
          len_next   = right_len;
        end
      end
      arfl_pkg::C_TRIM_TAIL: begin
        if (is_k) len_next = rem;
      end
      arfl_pkg::C_SPLIT_FIX: begin
        if (is_k) begin
          len_next = work.addr - start;
        end else if (is_kp1) begin
          start_next = work.end_addr;
          len_next   = left_start + left_len - work.end_addr;
        end else if (gt_kp1) begin
          start_next = left_start;
          len_next   = left_len;
        end
      end
      arfl_pkg::C_PAD_ONLY: begin
        if (is_k) len_next = pad;
      end
      arfl_pkg::C_SPLIT_ANY: begin
        if (is_k) begin
          len_next = pad;
        end else if (is_kp1) begin
          start_next = left_start + left_pad + work.size;
          len_next   = left_len - left_pad - work.size;
        end else if (gt_kp1) begin
          start_next = left_start;
          len_next   = left_len;
        end
      end
      arfl_pkg::C_FREE_A: begin
        if (is_k) begin
          start_next = work.addr;
          len_next   = len + work.size;
        end
      end
      arfl_pkg::C_A_MERGE: begin
        if (is_km1) begin
          len_next = len + right_len + work.size;
        end else if (is_k || gt_k) begin
          start_next = right_start;
          len_next   = right_len;
        end
      end
      arfl_pkg::C_FREE_B: begin
        if (is_k) len_next = len + work.size;
      end
      arfl_pkg::C_B_MERGE: begin
        if (is_k) begin
          len_next = len + work.size + right_len;
        end else if (gt_k) begin
          start_next = right_start;
          len_next   = right_len;
        end
      end
      arfl_pkg::C_INSERT: begin
        if (is_k) begin
          start_next = work.addr;
          len_next   = work.size;
        end else if (gt_k) begin
          start_next = left_start;
          len_next   = left_len;
        end
      end
      default: begin
        start_next = start;
        len_next   = len;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len   <= len_next;
  end

endmodule

[bench/tb_address_range_free_list_allocator.sv]
// testbench for address_range_free_list_allocator: self-checking run of directed and random
// requests against a built-in free-list predictor; depends on arfl_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_address_range_free_list_allocator;

  localparam int MAX_RANGES = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AREA_BASE = 64'h0000_0000_0001_0000;
  localparam logic [63:0] AREA_LEN = 64'h0000_0000_0004_0000;

  // free-list predictor plus the queue of responses still owed by the dut
  class alloc_scoreboard;
    logic [63:0]    range_start[MAX_RANGES];
    logic [63:0]    range_len[MAX_RANGES];
    int             range_cnt;
    bit             fresh;
    logic [63:0]    reg_base;
    logic [63:0]    reg_len;
    arfl_pkg::rsp_t owed_rsp[$];
    logic [63:0]    live_addr[$];
    logic [63:0]    live_len[$];
    int             errors;

    function new();
      range_cnt = 0;
      fresh = 1;
      reg_base = 0;
      reg_len = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [arfl_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      if (idx == arfl_pkg::CFG_BASE) reg_base = val;
      else if (idx == arfl_pkg::CFG_LENGTH) reg_len = val;
    endfunction

    function logic [63:0] region_room();
      logic [63:0] room;
      room = ~reg_base;
      return (reg_len > room) ? room : reg_len;
    endfunction

    function bit open_slot(int at, logic [63:0] s, logic [63:0] l);
      if (range_cnt >= MAX_RANGES) return 0;
      for (int k = range_cnt; k > at; k--) begin
        range_start[k] = range_start[k-1];
        range_len[k] = range_len[k-1];
      end
      range_start[at] = s;
      range_len[at] = l;
      range_cnt++;
      return 1;
    endfunction

    function void drop_slot(int at);
      for (int k = at; k < range_cnt - 1; k++) begin
        range_start[k] = range_start[k+1];
        range_len[k] = range_len[k+1];
      end
      range_cnt--;
    endfunction

    function logic [1:0] carve(logic [63:0] addr, logic [63:0] size, logic [63:0] align,
                               output logic [63:0] grant);
      logic [63:0] mask, fin, s, l, pad;
      grant = 0;
      if (align == 0) align = PAGE_BYTES;
      else if ((align & (align - 1)) != 0) return arfl_pkg::ST_INVALID;
      mask = align - 1;
      if (size == 0 || (addr & mask) != 0) return arfl_pkg::ST_INVALID;
      if (size > ~addr) return arfl_pkg::ST_OVERFLOW;
      fin = addr + size;
      if (addr != 0) begin
        // fixed placement: carve from the containing range
        if (addr < reg_base || fin - reg_base > region_room()) return arfl_pkg::ST_NOMEM;
        for (int i = 0; i < range_cnt; i++) begin
          s = range_start[i];
          l = range_len[i];
          if (addr < s) return arfl_pkg::ST_NOMEM;
          if (addr - s >= l || fin - s > l) continue;
          if (addr == s) begin
            range_start[i] += size;
            range_len[i] -= size;
            if (range_len[i] == 0) drop_slot(i);
          end else if (fin - s == l) begin
            range_len[i] -= size;
          end else begin
            if (!open_slot(i + 1, fin, s + l - fin)) return arfl_pkg::ST_NOMEM;
            range_len[i] = addr - s;
          end
          grant = addr;
          return arfl_pkg::ST_OK;
        end
        return arfl_pkg::ST_NOMEM;
      end
      // first fit with alignment pad left free
      for (int i = 0; i < range_cnt; i++) begin
        s = range_start[i];
        l = range_len[i];
        if (l < size) continue;
        pad = ((s & mask) != 0) ? align - (s & mask) : 64'd0;
        if (l - size < pad) continue;
        if (pad == 0) begin
          range_start[i] += size;
          range_len[i] -= size;
          if (range_len[i] == 0) drop_slot(i);
        end else if (l - size == pad) begin
          range_len[i] = pad;
        end else begin
          if (!open_slot(i, s, pad)) return arfl_pkg::ST_NOMEM;
          range_start[i+1] = s + pad + size;
          range_len[i+1] = l - pad - size;
        end
        grant = s + pad;
        return arfl_pkg::ST_OK;
      end
      return arfl_pkg::ST_NOMEM;
    endfunction

    function logic [1:0] give_back(logic [63:0] addr, logic [63:0] size);
      logic [63:0] fin, s, l;
      if (size > ~addr) return arfl_pkg::ST_OVERFLOW;
      if (size == 0) return arfl_pkg::ST_OK;
      fin = addr + size;
      for (int i = 0; i < range_cnt; i++) begin
        s = range_start[i];
        l = range_len[i];
        if (s == fin) begin
          // joins the range above, maybe the one below too
          range_start[i] = addr;
          range_len[i] = l + size;
          if (i > 0 && range_start[i-1] + range_len[i-1] == addr) begin
            range_len[i-1] += range_len[i];
            drop_slot(i);
          end
          return arfl_pkg::ST_OK;
        end
        if (s + l == addr) begin
          range_len[i] = l + size;
          if (i + 1 < range_cnt && range_start[i+1] == s + range_len[i]) begin
            range_len[i] += range_len[i+1];
            drop_slot(i + 1);
          end
          return arfl_pkg::ST_OK;
        end
        if (addr < s) begin
          return open_slot(i, addr, size) ? arfl_pkg::ST_OK : arfl_pkg::ST_NOMEM;
        end
      end
      return open_slot(range_cnt, addr, size) ? arfl_pkg::ST_OK : arfl_pkg::ST_NOMEM;
    endfunction

    function logic [1:0] probe(logic [63:0] addr, logic [63:0] size, output logic taken);
      logic [63:0] fin;
      taken = 0;
      if (size > ~addr) return arfl_pkg::ST_OVERFLOW;
      fin = addr + size;
      for (int i = 0; i < range_cnt; i++) begin
        if (fin <= range_start[i]) break;
        if (addr < range_start[i] + range_len[i]) return arfl_pkg::ST_OK;
      end
      taken = 1;
      return arfl_pkg::ST_OK;
    endfunction

    function void note_request(arfl_pkg::req_t r);
      arfl_pkg::rsp_t e;
      logic [63:0]    grant;
      logic           taken;
      grant = 0;
      taken = 0;
      // first real operation loads the whole region
      if (r.func != arfl_pkg::FN_BAD && fresh) begin
        range_cnt = 0;
        if (region_room() != 0) begin
          range_start[0] = reg_base;
          range_len[0] = region_room();
          range_cnt = 1;
        end
        fresh = 0;
      end
      case (r.func)
        arfl_pkg::FN_ALLOC: begin
          e.status = carve(r.req_address, r.req_length, r.req_alignment, grant);
        end
        arfl_pkg::FN_FREE:  e.status = give_back(r.req_address, r.req_length);
        arfl_pkg::FN_TEST:  e.status = probe(r.req_address, r.req_length, taken);
        default:            e.status = arfl_pkg::ST_INVALID;
      endcase
      if (e.status != arfl_pkg::ST_OK) begin
        grant = 0;
        taken = 0;
      end
      if (r.func == arfl_pkg::FN_ALLOC && e.status == arfl_pkg::ST_OK) begin
        live_addr.push_back(grant);
        live_len.push_back(r.req_length);
      end
      e.granted_address = grant;
      e.span_allocated = taken;
      owed_rsp.push_back(e);
    endfunction

    function void check_response(arfl_pkg::rsp_t got);
      arfl_pkg::rsp_t e;
      if (owed_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      e = owed_rsp.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.granted_address !== e.granted_address) begin
        $display("%0t: granted_address expected %h actual %h", $time,
                 e.granted_address, got.granted_address);
        errors++;
      end
      if (got.span_allocated !== e.span_allocated) begin
        $display("%0t: span_allocated expected %0d actual %0d", $time,
                 e.span_allocated, got.span_allocated);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           req_valid;
  logic                           req_stall;
  arfl_pkg::req_t                 req;
  logic                           rsp_valid;
  logic                           rsp_stall;
  arfl_pkg::rsp_t                 rsp;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [arfl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_data;

  alloc_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  cycles;

  address_range_free_list_allocator #(
    .MAX_RANGES(MAX_RANGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // response side: check accepted beats, stall at random
  initial rsp_stall = 0;
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_cfg(logic [arfl_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  // one request beat, with random idle cycles before it
  task automatic send_req(arfl_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!(req_valid && !req_stall));
    sb.note_request(r);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.owed_rsp.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic arfl_pkg::req_t make_req(logic [1:0] f, logic [63:0] a, logic [63:0] l,
                                              logic [63:0] al);
    arfl_pkg::req_t r;
    r.func = f;
    r.req_address = a;
    r.req_length = l;
    r.req_alignment = al;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly sane traffic inside the region, some noise
  function automatic arfl_pkg::req_t pick_req();
    arfl_pkg::req_t r;
    logic [63:0]    al, a, l;
    int             k, roll;
    roll = $urandom_range(99);
    if (roll < 8) return make_req(2'($urandom), rand64(), rand64(), rand64());
    case ($urandom_range(3))
      0: al = 0;
      1: al = 64'd1 << $urandom_range(0, 14);
      2: al = ($urandom_range(9) == 0) ? 64'd1 << $urandom_range(15, 63) : 64'd0;
      default: al = ($urandom_range(4) == 0) ? 64'($urandom_range(3, 1000)) : 64'd0;
    endcase
    l = ($urandom_range(1) != 0) ? 64'($urandom_range(1, 4)) * PAGE_BYTES
                                 : 64'($urandom_range(1, 700));
    a = AREA_BASE + 64'($urandom_range(0, int'(AREA_LEN) - 1));
    if (roll < 45) begin
      if ($urandom_range(2) == 0) begin
        // fixed placement, aligned
        if (al == 0 || (al & (al - 1)) != 0) al = 0;
        a = a & ~((al == 0 ? 64'(PAGE_BYTES) : al) - 1);
        return make_req(arfl_pkg::FN_ALLOC, a, l, al);
      end
      return make_req(arfl_pkg::FN_ALLOC, 64'd0, l, al);
    end
    if (roll < 78) begin
      if (sb.live_addr.size() != 0 && $urandom_range(2) != 0) begin
        k = $urandom_range(sb.live_addr.size() - 1);
        r = make_req(arfl_pkg::FN_FREE, sb.live_addr[k], sb.live_len[k], rand64());
        sb.live_addr.delete(k);
        sb.live_len.delete(k);
        return r;
      end
      return make_req(arfl_pkg::FN_FREE, a, 64'($urandom_range(1, 300)), rand64());
    end
    return make_req(arfl_pkg::FN_TEST, a, 64'($urandom_range(0, 9000)), rand64());
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_req(pick_req());
  endtask

  initial begin
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = arfl_pkg::CFG_BASE;
    cfg_data = 0;
    send_idle_pct = 23;
    recv_idle_pct = 47;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_cfg(arfl_pkg::CFG_BASE, AREA_BASE);
    write_cfg(arfl_pkg::CFG_LENGTH, AREA_LEN);

    // directed corners
    send_req(make_req(arfl_pkg::FN_BAD, 64'd5, 64'd5, 64'd5));               // unknown func
    send_req(make_req(arfl_pkg::FN_TEST, AREA_BASE, 64'd0, 64'd0));          // zero-length test
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, 64'd0, 64'd0));             // zero-length alloc
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, 64'd16, 64'd3));            // bad alignment
    send_req(make_req(arfl_pkg::FN_ALLOC, AREA_BASE + 1, 64'd16, 64'd0));    // fixed not aligned
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, ALL_ONES, 64'd1));          // huge size
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, 64'd1, 64'd1));
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, 64'd100, 64'd0));           // page pad
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, 64'd8, 64'h8000_0000_0000_0000));
    send_req(make_req(arfl_pkg::FN_ALLOC, AREA_BASE + 64'h8000, 64'h1000, 64'd0));
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'h1000, 64'h1000, 64'd0));       // outside region
    send_req(make_req(arfl_pkg::FN_ALLOC, 64'd0, AREA_LEN, 64'd1));          // no memory
    send_req(make_req(arfl_pkg::FN_FREE, AREA_BASE, 64'd0, 64'd0));          // zero-length free
    send_req(make_req(arfl_pkg::FN_FREE, ALL_ONES, 64'd2, 64'd0));           // free overflow
    send_req(make_req(arfl_pkg::FN_TEST, ALL_ONES, ALL_ONES, ALL_ONES));     // test overflow
    send_req(make_req(arfl_pkg::FN_TEST, AREA_BASE + 64'h8000, 64'h1000, 64'd0));
    send_req(make_req(arfl_pkg::FN_FREE, AREA_BASE + 64'h8000, 64'h1000, 64'd0)); // coalesce
    send_req(make_req(arfl_pkg::FN_FREE, AREA_BASE, 64'd1, 64'd0));
    send_req(make_req(arfl_pkg::FN_FREE, 64'd0, 64'd1, 64'd0));
    send_req(make_req(arfl_pkg::FN_TEST, ALL_ONES, 64'd0, 64'd0));
    send_req(make_req(arfl_pkg::FN_BAD, ALL_ONES, ALL_ONES, ALL_ONES));

    random_phase(160);
    // hold off until the dut has answered everything, then move the bounds
    drain();
    write_cfg(arfl_pkg::CFG_BASE, 64'd0);
    write_cfg(arfl_pkg::CFG_LENGTH, 64'd0);

    send_idle_pct = 47;
    recv_idle_pct = 23;
    random_phase(160);
    drain();
    write_cfg(arfl_pkg::CFG_BASE, ALL_ONES);
    write_cfg(arfl_pkg::CFG_LENGTH, ALL_ONES);
    random_phase(40);
    drain();
    write_cfg(arfl_pkg::CFG_BASE, 64'd0);
    write_cfg(arfl_pkg::CFG_LENGTH, ALL_ONES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(140);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.owed_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
